@@ src/date_time_field_editor_assert.svh @@
// Assertion macros used by the checker file of the date and time editor.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DATE_TIME_FIELD_EDITOR_ASSERT_SVH
`define DATE_TIME_FIELD_EDITOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DTFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DTFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dtfe_pkg.sv @@
package dtfe_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OP_W     = 3;
    localparam int FIELD_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0] FIRST_YEAR_RST = 12'd2000;
    localparam logic [YEAR_W-1:0] LAST_YEAR_RST  = 12'd2099;

    // Opcodes of an input transaction.
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_PLUS   = 3'd1;
    localparam logic [OP_W-1:0] OP_MINUS  = 3'd2;
    localparam logic [OP_W-1:0] OP_SWITCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd4;
    localparam logic [OP_W-1:0] OP_OK     = 3'd5;

    // Field selector codes.
    localparam logic [FIELD_W-1:0] FLD_NONE   = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_YEAR   = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_MONTH  = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_DAY    = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_HOUR   = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_MINUTE = 3'd5;
    localparam logic [FIELD_W-1:0] FLD_SECOND = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_YEAR  = 1'b1;

    localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

    // Reciprocal of 25 scaled by 2^17; exact floor quotient for 12-bit years.
    localparam logic [12:0] RECIP25     = 13'd5243;
    localparam int          RECIP25_SH  = 17;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } dtfe_item_t;

    typedef struct packed {
        logic       vld;
        dtfe_item_t item;
    } dtfe_hold_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [FIELD_W-1:0]  field;
    } dtfe_time_t;

    // Length of a month; anything outside 1..12 counts as 31 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ src/dtfe_in_reg.sv @@
module dtfe_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dtfe_pkg::dtfe_item_t in_item,
    input  logic                take,
    output dtfe_pkg::dtfe_hold_t hold
);

    logic                 vld_reg;
    logic                 vld_next;
    dtfe_pkg::dtfe_item_t item_reg;
    logic                 accept;

    // The held transaction blocks the input only while it cannot move on.
    assign in_stall = vld_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign hold.vld  = vld_reg;
    assign hold.item = item_reg;

endmodule

@@ src/dtfe_next.sv @@
module dtfe_next (
    input  dtfe_pkg::dtfe_time_t             cur,
    input  dtfe_pkg::dtfe_item_t             item,
    input  logic [dtfe_pkg::YEAR_W-1:0]      first_year,
    input  logic [dtfe_pkg::YEAR_W-1:0]      last_year,
    output dtfe_pkg::dtfe_time_t             nxt,
    output logic                             commit_next,
    output logic                             leave_next
);

    logic [24:0]                    prod;
    logic [7:0]                     quot25;
    logic [dtfe_pkg::YEAR_W-1:0]    back25;
    logic                           div25;
    logic                           leap;
    logic [dtfe_pkg::DAY_W-1:0]     len;
    logic [dtfe_pkg::YEAR_W:0]      year_inc;
    logic [dtfe_pkg::DAY_W:0]       day_inc;

    // Leap year: divisible by 4, and not by 100 unless also by 400.
    // Divisibility by 25 is checked through a reciprocal quotient.
    assign prod   = {13'd0, cur.year} * {12'd0, dtfe_pkg::RECIP25};
    assign quot25 = prod[dtfe_pkg::RECIP25_SH +: 8];
    assign back25 = {quot25, 4'd0} + {1'b0, quot25, 3'd0} + {4'd0, quot25};
    assign div25  = (back25 == cur.year);
    assign leap   = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));
    assign len    = dtfe_pkg::month_days(cur.month, leap);

    assign year_inc = {1'b0, cur.year} + 13'd1;
    assign day_inc  = {1'b0, cur.day} + 6'd1;

    always_comb
    begin
        nxt         = cur;
        commit_next = 1'b0;
        leave_next  = 1'b0;
        case (item.opcode)
            dtfe_pkg::OP_LOAD:
            begin
                nxt.year   = item.year;
                nxt.month  = item.month;
                nxt.day    = item.day;
                nxt.hour   = item.hour;
                nxt.minute = item.minute;
                nxt.second = item.second;
                nxt.field  = dtfe_pkg::FLD_MINUTE;
            end
            dtfe_pkg::OP_PLUS:
            begin
                case (cur.field)
                    dtfe_pkg::FLD_YEAR:
                        nxt.year = (year_inc > {1'b0, last_year}) ? first_year
                                                                   : year_inc[11:0];
                    dtfe_pkg::FLD_MONTH:
                        nxt.month = (cur.month >= dtfe_pkg::MONTH_MAX) ? 4'd1
                                                                       : cur.month + 4'd1;
                    dtfe_pkg::FLD_DAY:
                        nxt.day = (day_inc > {1'b0, len}) ? 5'd1 : day_inc[4:0];
                    dtfe_pkg::FLD_HOUR:
                        nxt.hour = (cur.hour >= dtfe_pkg::HOUR_MAX) ? 5'd0
                                                                    : cur.hour + 5'd1;
                    dtfe_pkg::FLD_MINUTE:
                        nxt.minute = (cur.minute >= dtfe_pkg::MINUTE_MAX) ? 6'd0
                                                                          : cur.minute + 6'd1;
                    dtfe_pkg::FLD_SECOND:
                        nxt.second = (cur.second >= dtfe_pkg::SECOND_MAX) ? 6'd0
                                                                          : cur.second + 6'd1;
                    default:
                        nxt = cur;
                endcase
            end
            dtfe_pkg::OP_MINUS:
            begin
                case (cur.field)
                    dtfe_pkg::FLD_YEAR:
                        nxt.year = (cur.year <= first_year) ? first_year : cur.year - 12'd1;
                    dtfe_pkg::FLD_MONTH:
                        nxt.month = (cur.month <= 4'd1) ? dtfe_pkg::MONTH_MAX
                                                        : cur.month - 4'd1;
                    dtfe_pkg::FLD_DAY:
                        nxt.day = (cur.day <= 5'd1) ? len : cur.day - 5'd1;
                    dtfe_pkg::FLD_HOUR:
                        nxt.hour = (cur.hour == 5'd0) ? dtfe_pkg::HOUR_MAX : cur.hour - 5'd1;
                    dtfe_pkg::FLD_MINUTE:
                        nxt.minute = (cur.minute == 6'd0) ? dtfe_pkg::MINUTE_MAX
                                                          : cur.minute - 6'd1;
                    dtfe_pkg::FLD_SECOND:
                        nxt.second = (cur.second == 6'd0) ? dtfe_pkg::SECOND_MAX
                                                          : cur.second - 6'd1;
                    default:
                        nxt = cur;
                endcase
            end
            dtfe_pkg::OP_SWITCH:
            begin
                nxt.field = (cur.field >= dtfe_pkg::FLD_SECOND) ? dtfe_pkg::FLD_YEAR
                                                                : cur.field + 3'd1;
            end
            dtfe_pkg::OP_CANCEL:
            begin
                leave_next = 1'b1;
            end
            dtfe_pkg::OP_OK:
            begin
                commit_next = 1'b1;
                leave_next  = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

@@ src/date_time_field_editor.sv @@
// An accepted transaction waits in the input register; one short combinational
// step then updates the edit state as it moves into the state/result registers,
// which show its result. Throughput: one transaction per cycle while out_stall is low.
// Reset (rst_n low, asynchronous): edited time and selection clear to zero, no
// transaction held, first_year returns to 2000 and last_year to 2099.
module date_time_field_editor (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [dtfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtfe_pkg::YEAR_W-1:0]     cfg_data,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dtfe_pkg::OP_W-1:0]       opcode,
    input  logic [dtfe_pkg::YEAR_W-1:0]     load_year,
    input  logic [dtfe_pkg::MONTH_W-1:0]    load_month,
    input  logic [dtfe_pkg::DAY_W-1:0]      load_day,
    input  logic [dtfe_pkg::HOUR_W-1:0]     load_hour,
    input  logic [dtfe_pkg::MINUTE_W-1:0]   load_minute,
    input  logic [dtfe_pkg::SECOND_W-1:0]   load_second,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dtfe_pkg::YEAR_W-1:0]     year_out,
    output logic [dtfe_pkg::MONTH_W-1:0]    month_out,
    output logic [dtfe_pkg::DAY_W-1:0]      day_out,
    output logic [dtfe_pkg::HOUR_W-1:0]     hour_out,
    output logic [dtfe_pkg::MINUTE_W-1:0]   minute_out,
    output logic [dtfe_pkg::SECOND_W-1:0]   second_out,
    output logic [dtfe_pkg::FIELD_W-1:0]    field_out,
    output logic                            commit,
    output logic                            leave
);

    // Configuration registers. They must only be written, by the user, while the editor is idle,
    // so no transaction in flight can see a change part-way through; the block does not enforce it.
    logic [dtfe_pkg::YEAR_W-1:0] first_year_reg;
    logic [dtfe_pkg::YEAR_W-1:0] last_year_reg;

    // The edit state doubles as the result payload: it only changes when a
    // transaction moves into the output stage, which can only happen once the
    // previous result has been taken, so a stalled result stays steady.
    dtfe_pkg::dtfe_time_t state_reg;
    dtfe_pkg::dtfe_time_t state_next;
    logic                 commit_reg;
    logic                 commit_next;
    logic                 leave_reg;
    logic                 leave_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    dtfe_pkg::dtfe_item_t in_item;
    dtfe_pkg::dtfe_hold_t hold;
    logic                 take;
    logic                 fire;

    assign in_item.opcode = opcode;
    assign in_item.year   = load_year;
    assign in_item.month  = load_month;
    assign in_item.day    = load_day;
    assign in_item.hour   = load_hour;
    assign in_item.minute = load_minute;
    assign in_item.second = load_second;

    // The output stage can take a new result when it is empty or its current
    // result leaves in this cycle.
    assign take = !out_valid_reg || !out_stall;
    assign fire = hold.vld && take;

    dtfe_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (take),
        .hold     (hold)
    );

    dtfe_next u_next (
        .cur         (state_reg),
        .item        (hold.item),
        .first_year  (first_year_reg),
        .last_year   (last_year_reg),
        .nxt         (state_next),
        .commit_next (commit_next),
        .leave_next  (leave_next)
    );

    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_year_reg <= dtfe_pkg::FIRST_YEAR_RST;
            last_year_reg  <= dtfe_pkg::LAST_YEAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtfe_pkg::CFG_FIRST_YEAR: first_year_reg <= cfg_data;
                dtfe_pkg::CFG_LAST_YEAR:  last_year_reg  <= cfg_data;
                default:                  first_year_reg <= first_year_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            commit_reg    <= 1'b0;
            leave_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg  <= state_next;
                commit_reg <= commit_next;
                leave_reg  <= leave_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign year_out   = state_reg.year;
    assign month_out  = state_reg.month;
    assign day_out    = state_reg.day;
    assign hour_out   = state_reg.hour;
    assign minute_out = state_reg.minute;
    assign second_out = state_reg.second;
    assign field_out  = state_reg.field;
    assign commit     = commit_reg;
    assign leave      = leave_reg;

endmodule

@@ src/dtfe_checker.sv @@
`include "date_time_field_editor_assert.svh"

module dtfe_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [dtfe_pkg::YEAR_W-1:0]     year_out,
    input logic [dtfe_pkg::FIELD_W-1:0]    field_out,
    input logic                            commit,
    input logic                            leave
);

    // A commit always exits the editor as well.
    `DTFE_ASSERT_NOW(a_commit_leaves, out_valid && commit, leave, "commit without leave")

    // The selector never goes beyond the seconds field.
    `DTFE_ASSERT_NOW(a_field_range, out_valid, field_out <= dtfe_pkg::FLD_SECOND, "field selector out of range")

    // The input is only held off while a finished result waits downstream.
    `DTFE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                     "input stalled with the output free")

    // A stalled result stays on the port unchanged.
    `DTFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                      out_valid && $stable(year_out) && $stable(field_out) && $stable(leave),
                      "stalled result changed")

endmodule

bind date_time_field_editor dtfe_checker u_dtfe_checker (.*);

@@ tb/testbench.sv @@
module testbench;

    // The package names the six real opcodes only; the two spare codes are
    // named here so that the stimulus never carries a bare opcode number.
    localparam logic [dtfe_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [dtfe_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_EVENTS   = 1700;
    localparam int WINDOW_EVERY    = 400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;

    // What the editor shows after one transaction: the edited time with the
    // selected field, and the two exit flags.
    typedef struct packed {
        dtfe_pkg::dtfe_time_t shown;
        logic                 commit;
        logic                 leave;
    } editor_view_t;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_we      = 1'b0;
    logic [dtfe_pkg::CFG_IDX_W-1:0]      cfg_index   = dtfe_pkg::CFG_FIRST_YEAR;
    logic [dtfe_pkg::YEAR_W-1:0]         cfg_data    = '0;
    logic                                in_valid    = 1'b0;
    logic                                in_stall;
    logic [dtfe_pkg::OP_W-1:0]           opcode      = dtfe_pkg::OP_LOAD;
    logic [dtfe_pkg::YEAR_W-1:0]         load_year   = '0;
    logic [dtfe_pkg::MONTH_W-1:0]        load_month  = '0;
    logic [dtfe_pkg::DAY_W-1:0]          load_day    = '0;
    logic [dtfe_pkg::HOUR_W-1:0]         load_hour   = '0;
    logic [dtfe_pkg::MINUTE_W-1:0]       load_minute = '0;
    logic [dtfe_pkg::SECOND_W-1:0]       load_second = '0;
    logic                                out_valid;
    logic                                out_stall   = 1'b0;
    logic [dtfe_pkg::YEAR_W-1:0]         year_out;
    logic [dtfe_pkg::MONTH_W-1:0]        month_out;
    logic [dtfe_pkg::DAY_W-1:0]          day_out;
    logic [dtfe_pkg::HOUR_W-1:0]         hour_out;
    logic [dtfe_pkg::MINUTE_W-1:0]       minute_out;
    logic [dtfe_pkg::SECOND_W-1:0]       second_out;
    logic [dtfe_pkg::FIELD_W-1:0]        field_out;
    logic                                commit;
    logic                                leave;

    // Our own copy of the editor: the edited time and selection, and the
    // year window as last written through the configuration port.
    dtfe_pkg::dtfe_time_t                edit_state   = '0;
    logic [dtfe_pkg::YEAR_W-1:0]         year_floor   = dtfe_pkg::FIRST_YEAR_RST;
    logic [dtfe_pkg::YEAR_W-1:0]         year_ceiling = dtfe_pkg::LAST_YEAR_RST;

    // Views still owed by the editor, oldest first.
    editor_view_t                        views_due[$];

    int                                  mismatches       = 0;
    int                                  quiet_cycles     = 0;
    int                                  hold_left        = 0;
    bit                                  hold_off_request = 1'b0;
    bit                                  sender_idles     = 1'b1;
    bit                                  receiver_idles   = 1'b1;

    date_time_field_editor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .load_year   (load_year),
        .load_month  (load_month),
        .load_day    (load_day),
        .load_hour   (load_hour),
        .load_minute (load_minute),
        .load_second (load_second),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .hour_out    (hour_out),
        .minute_out  (minute_out),
        .second_out  (second_out),
        .field_out   (field_out),
        .commit      (commit),
        .leave       (leave)
    );

    always #HALF_PERIOD clk = ~clk;

    // Month length with Gregorian leap years. A month outside 1..12 is
    // treated as a 31-day month, which is what the editor does with a
    // nonsense month captured on load.
    function automatic int days_in(input int y, input int m);
        if (m < 1 || m > 12)
            return 31;
        if (m == 2)
            return ((y % 4 == 0) && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Applies one key event to our copy of the editor and returns what the
    // editor should show afterwards.
    function automatic editor_view_t next_view(input dtfe_pkg::dtfe_item_t ev);
        editor_view_t v;
        int           n;
        v.commit = 1'b0;
        v.leave  = 1'b0;
        case (ev.opcode)
            dtfe_pkg::OP_LOAD:
            begin
                edit_state.year   = ev.year;
                edit_state.month  = ev.month;
                edit_state.day    = ev.day;
                edit_state.hour   = ev.hour;
                edit_state.minute = ev.minute;
                edit_state.second = ev.second;
                edit_state.field  = dtfe_pkg::FLD_MINUTE;
            end
            dtfe_pkg::OP_PLUS:
            begin
                case (edit_state.field)
                    dtfe_pkg::FLD_YEAR:
                    begin
                        // Year plus wraps round to the bottom of the window.
                        n = edit_state.year;
                        edit_state.year = (n + 1 > int'(year_ceiling)) ? year_floor
                                                                       : edit_state.year + 1'b1;
                    end
                    dtfe_pkg::FLD_MONTH:
                        edit_state.month = (edit_state.month >= dtfe_pkg::MONTH_MAX)
                                           ? 4'd1 : edit_state.month + 1'b1;
                    dtfe_pkg::FLD_DAY:
                    begin
                        n = days_in(edit_state.year, edit_state.month);
                        edit_state.day = (int'(edit_state.day) + 1 > n) ? 5'd1
                                                                        : edit_state.day + 1'b1;
                    end
                    dtfe_pkg::FLD_HOUR:
                        edit_state.hour = (edit_state.hour >= dtfe_pkg::HOUR_MAX)
                                          ? '0 : edit_state.hour + 1'b1;
                    dtfe_pkg::FLD_MINUTE:
                        edit_state.minute = (edit_state.minute >= dtfe_pkg::MINUTE_MAX)
                                            ? '0 : edit_state.minute + 1'b1;
                    dtfe_pkg::FLD_SECOND:
                        edit_state.second = (edit_state.second >= dtfe_pkg::SECOND_MAX)
                                            ? '0 : edit_state.second + 1'b1;
                    default:
                        ;
                endcase
            end
            dtfe_pkg::OP_MINUS:
            begin
                case (edit_state.field)
                    // Year minus does not wrap: it sticks at the bottom of the window.
                    dtfe_pkg::FLD_YEAR:
                        edit_state.year = (edit_state.year <= year_floor) ? year_floor
                                                                          : edit_state.year - 1'b1;
                    dtfe_pkg::FLD_MONTH:
                        edit_state.month = (edit_state.month <= 4'd1) ? dtfe_pkg::MONTH_MAX
                                                                      : edit_state.month - 1'b1;
                    dtfe_pkg::FLD_DAY:
                    begin
                        n = days_in(edit_state.year, edit_state.month);
                        edit_state.day = (edit_state.day <= 5'd1) ? dtfe_pkg::DAY_W'(n)
                                                                  : edit_state.day - 1'b1;
                    end
                    dtfe_pkg::FLD_HOUR:
                        edit_state.hour = (edit_state.hour == '0) ? dtfe_pkg::HOUR_MAX
                                                                  : edit_state.hour - 1'b1;
                    dtfe_pkg::FLD_MINUTE:
                        edit_state.minute = (edit_state.minute == '0) ? dtfe_pkg::MINUTE_MAX
                                                                      : edit_state.minute - 1'b1;
                    dtfe_pkg::FLD_SECOND:
                        edit_state.second = (edit_state.second == '0) ? dtfe_pkg::SECOND_MAX
                                                                      : edit_state.second - 1'b1;
                    default:
                        ;
                endcase
            end
            dtfe_pkg::OP_SWITCH:
                edit_state.field = (edit_state.field >= dtfe_pkg::FLD_SECOND)
                                   ? dtfe_pkg::FLD_YEAR : edit_state.field + 1'b1;
            dtfe_pkg::OP_CANCEL:
                v.leave = 1'b1;
            dtfe_pkg::OP_OK:
            begin
                v.commit = 1'b1;
                v.leave  = 1'b1;
            end
            default:
                ;
        endcase
        v.shown = edit_state;
        return v;
    endfunction

    function automatic string view_text(input editor_view_t v);
        return $sformatf("year %0d month %0d day %0d %0d:%0d:%0d field %0d commit %0b leave %0b",
                         v.shown.year, v.shown.month, v.shown.day, v.shown.hour,
                         v.shown.minute, v.shown.second, v.shown.field, v.commit, v.leave);
    endfunction

    function automatic dtfe_pkg::dtfe_item_t load_event(input int y, input int m, input int d,
                                                        input int h, input int mi, input int s);
        dtfe_pkg::dtfe_item_t ev;
        ev.opcode = dtfe_pkg::OP_LOAD;
        ev.year   = dtfe_pkg::YEAR_W'(y);
        ev.month  = dtfe_pkg::MONTH_W'(m);
        ev.day    = dtfe_pkg::DAY_W'(d);
        ev.hour   = dtfe_pkg::HOUR_W'(h);
        ev.minute = dtfe_pkg::MINUTE_W'(mi);
        ev.second = dtfe_pkg::SECOND_W'(s);
        return ev;
    endfunction

    // Any event other than a load; the load fields carry random junk, which
    // the editor must ignore.
    function automatic dtfe_pkg::dtfe_item_t key_event(input logic [dtfe_pkg::OP_W-1:0] op);
        dtfe_pkg::dtfe_item_t ev;
        ev.opcode = op;
        ev.year   = dtfe_pkg::YEAR_W'($urandom);
        ev.month  = dtfe_pkg::MONTH_W'($urandom);
        ev.day    = dtfe_pkg::DAY_W'($urandom);
        ev.hour   = dtfe_pkg::HOUR_W'($urandom);
        ev.minute = dtfe_pkg::MINUTE_W'($urandom);
        ev.second = dtfe_pkg::SECOND_W'($urandom);
        return ev;
    endfunction

    // A load with content chosen to reach the interesting corners: years at
    // the edges of the window and around century leap rules, February and
    // month ends, and now and then values beyond the legal ranges.
    function automatic dtfe_pkg::dtfe_item_t random_load();
        int y, m, d, h, mi, s;
        case ($urandom_range(0, 3))
            0:       y = year_floor + $urandom_range(0, 3);
            1:       y = year_ceiling - $urandom_range(0, 3);
            2:       y = $urandom_range(0, 4095);
            default: y = $urandom_range(1896, 2404);
        endcase
        if ($urandom_range(0, 9) == 0)
            m = $urandom_range(0, 15);
        else if ($urandom_range(0, 2) == 0)
            m = 2;
        else
            m = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0)
            d = $urandom_range(0, 31);
        else if ($urandom_range(0, 1) == 0)
            d = $urandom_range(26, 31);
        else
            d = $urandom_range(1, 31);
        h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
        s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
        return load_event(y, m, d, h, mi, s);
    endfunction

    function automatic dtfe_pkg::dtfe_item_t random_edit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return key_event(dtfe_pkg::OP_PLUS);
        if (pick < 70)
            return key_event(dtfe_pkg::OP_MINUS);
        if (pick < 92)
            return key_event(dtfe_pkg::OP_SWITCH);
        if (pick < 94)
            return key_event(OP_SPARE_6);
        if (pick < 96)
            return key_event(OP_SPARE_7);
        if (pick < 98)
            return key_event(dtfe_pkg::OP_CANCEL);
        return key_event(dtfe_pkg::OP_OK);
    endfunction

    // Presents one transaction and holds it, unchanged, until the editor
    // takes it. When the sender may idle, it first drops valid for a random
    // number of cycles. The expected view is worked out at the edge where
    // the transaction is accepted.
    task automatic offer_event(input dtfe_pkg::dtfe_item_t ev);
        while (sender_idles && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= ev.opcode;
        load_year   <= ev.year;
        load_month  <= ev.month;
        load_day    <= ev.day;
        load_hour   <= ev.hour;
        load_minute <= ev.minute;
        load_second <= ev.second;
        do
            @(posedge clk);
        while (in_stall);
        views_due.push_back(next_view(ev));
    endtask

    // Stops offering and waits for every owed view. At least one edge always
    // passes, so the caller never drives valid twice within one time step.
    task automatic wait_for_views();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (views_due.size() != 0);
    endtask

    // Both year registers are written back to back, and only once the editor
    // has nothing left in flight.
    task automatic set_year_window(input int lo, input int hi);
        wait_for_views();
        cfg_we    <= 1'b1;
        cfg_index <= dtfe_pkg::CFG_FIRST_YEAR;
        cfg_data  <= dtfe_pkg::YEAR_W'(lo);
        @(posedge clk);
        cfg_index <= dtfe_pkg::CFG_LAST_YEAR;
        cfg_data  <= dtfe_pkg::YEAR_W'(hi);
        @(posedge clk);
        cfg_we       <= 1'b0;
        year_floor   = dtfe_pkg::YEAR_W'(lo);
        year_ceiling = dtfe_pkg::YEAR_W'(hi);
    endtask

    // Straight after reset nothing is selected: plus and minus must leave
    // the cleared time alone, the spare opcodes do nothing, cancel and ok
    // only raise their flags, and switch picks the year.
    task automatic test_no_selection();
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
        offer_event(key_event(OP_SPARE_6));
        offer_event(key_event(OP_SPARE_7));
        offer_event(key_event(dtfe_pkg::OP_CANCEL));
        offer_event(key_event(dtfe_pkg::OP_OK));
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
    endtask

    // Every field is loaded at the top of its register range; second, year and hour are
    // stepped both ways, minute and month up, day down, then an all-zero load and a minus.
    task automatic test_field_extremes();
        offer_event(load_event(4095, 15, 31, 31, 63, 63));
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
        // From the second field the selection wraps round to the year.
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
        offer_event(key_event(dtfe_pkg::OP_SWITCH));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
        offer_event(key_event(dtfe_pkg::OP_PLUS));
        offer_event(load_event(0, 0, 0, 0, 0, 0));
        offer_event(key_event(dtfe_pkg::OP_MINUS));
    endtask

    // The year window at its extremes, inverted, and straddling the century years 2100
    // and 1900, which are not leap years. Each window is exercised with
    // a wrap past the top, a clamp at the bottom and February day edits.
    task automatic test_year_window();
        int lo_years[5];
        int hi_years[5];
        lo_years = '{0, 4095, 2096, 1896, 0};
        hi_years = '{4095, 0, 2104, 1904, 0};
        for (int w = 0; w < 5; w++)
        begin
            set_year_window(lo_years[w], hi_years[w]);
            offer_event(load_event(hi_years[w], 2, 28, 12, 30, 0));
            offer_event(key_event(dtfe_pkg::OP_SWITCH));
            offer_event(key_event(dtfe_pkg::OP_SWITCH));
            offer_event(key_event(dtfe_pkg::OP_PLUS));
            offer_event(key_event(dtfe_pkg::OP_MINUS));
            offer_event(key_event(dtfe_pkg::OP_PLUS));
            offer_event(key_event(dtfe_pkg::OP_PLUS));
            offer_event(key_event(dtfe_pkg::OP_SWITCH));
            offer_event(key_event(dtfe_pkg::OP_SWITCH));
            offer_event(key_event(dtfe_pkg::OP_PLUS));
            offer_event(key_event(dtfe_pkg::OP_PLUS));
            offer_event(key_event(dtfe_pkg::OP_MINUS));
            offer_event(key_event(dtfe_pkg::OP_MINUS));
            offer_event(key_event(dtfe_pkg::OP_MINUS));
        end
        set_year_window(dtfe_pkg::FIRST_YEAR_RST, dtfe_pkg::LAST_YEAR_RST);
    endtask

    // The receiver stops taking views for a long stretch while the sender
    // keeps offering back to back, so the editor fills up and stalls its input.
    task automatic test_output_hold_off();
        hold_off_request = 1'b1;
        sender_idles     = 1'b0;
        offer_event(random_load());
        repeat (40)
            offer_event(random_edit());
        sender_idles = 1'b1;
    endtask

    // The sender stops in the middle of an edit session until everything
    // owed has come out, then carries on with the same session.
    task automatic test_sender_pause();
        offer_event(random_load());
        repeat (10)
            offer_event(random_edit());
        wait_for_views();
        repeat (10)
            offer_event(random_edit());
    endtask

    // The bulk of the run: edit sessions that start with a load, carry a
    // random run of mostly plus, minus and switch keys, and often end with ok or
    // cancel, mixed with stray keys. The year window moves now and then and
    // one long stretch runs with neither side idling.
    task automatic test_random_sessions();
        int sent;
        int next_window;
        int edits;
        dtfe_pkg::dtfe_item_t ev;
        sent        = 0;
        next_window = WINDOW_EVERY;
        while (sent < RANDOM_EVENTS)
        begin
            if (sent >= next_window)
            begin
                next_window += WINDOW_EVERY;
                case ($urandom_range(0, 4))
                    0:       set_year_window(0, 4095);
                    1:       set_year_window(4095, 0);
                    2:       set_year_window(dtfe_pkg::FIRST_YEAR_RST, dtfe_pkg::LAST_YEAR_RST);
                    3:       set_year_window($urandom_range(0, 4095), $urandom_range(0, 4095));
                    default:
                    begin
                        edits = $urandom_range(1500, 3900);
                        set_year_window(edits, edits + $urandom_range(0, 150));
                    end
                endcase
            end
            sender_idles   = !(sent >= 600 && sent < 900);
            receiver_idles = sender_idles;

            if ($urandom_range(0, 7) == 0)
            begin
                // A stray key of any kind, outside a well-formed session.
                ev = key_event(dtfe_pkg::OP_W'($urandom_range(0, 7)));
                if (ev.opcode == dtfe_pkg::OP_LOAD)
                    ev = random_load();
                offer_event(ev);
                if (ev.opcode != OP_SPARE_6 && ev.opcode != OP_SPARE_7)
                    sent++;
            end
            else
            begin
                offer_event(random_load());
                sent++;
                edits = $urandom_range(3, 24);
                repeat (edits)
                begin
                    ev = random_edit();
                    offer_event(ev);
                    if (ev.opcode != OP_SPARE_6 && ev.opcode != OP_SPARE_7)
                        sent++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    offer_event(key_event(($urandom_range(0, 1) == 0) ? dtfe_pkg::OP_OK
                                                                       : dtfe_pkg::OP_CANCEL));
                    sent++;
                end
            end
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Result side: every view taken from the editor is compared with the
    // oldest one owed. The stall for the next cycle is chosen here as well,
    // including the long hold-off, which this process counts down itself.
    always @(posedge clk)
    begin : view_check
        editor_view_t got;
        editor_view_t want;
        if (out_valid && !out_stall)
        begin
            got.shown.year   = year_out;
            got.shown.month  = month_out;
            got.shown.day    = day_out;
            got.shown.hour   = hour_out;
            got.shown.minute = minute_out;
            got.shown.second = second_out;
            got.shown.field  = field_out;
            got.commit       = commit;
            got.leave        = leave;
            if (views_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: view with none owed: %s", $time, view_text(got));
            end
            else
            begin
                want = views_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: view mismatch\n  expected %s\n  actual   %s",
                                 $time, view_text(want), view_text(got));
                end
            end
        end

        if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (receiver_idles)
            out_stall <= ($urandom_range(0, 99) < 36);
        else
            out_stall <= 1'b0;
    end

    // Watchdog: a run in which neither channel moves for too long has hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL date_time_field_editor");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_no_selection();
        test_field_extremes();
        test_year_window();
        test_output_hold_off();
        test_sender_pause();
        test_random_sessions();

        // Let anything stray drain out before the final verdict.
        wait_for_views();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && views_due.size() == 0)
            $display("PASS date_time_field_editor");
        else
            $display("FAIL date_time_field_editor");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/dtfe_pkg.sv
src/dtfe_in_reg.sv
src/dtfe_next.sv
src/date_time_field_editor.sv
src/dtfe_checker.sv
tb/testbench.sv
